// ----- sv/assert_macros.svh -----
// Assertion macros shared by the fixed-point ALU modules.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition implies another condition in the next cycle.
`define ASSERT_NEXT(label, cond, nxt, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (nxt)) \
      else $error(msg);

`endif

// ----- sv/fpa_pkg.sv -----
// Package for the fixed-point ALU: widths, opcodes and shared types.
// Depends on nothing.
`timescale 1ns / 1ps
package fpa_pkg;
   localparam int FRAC_BITS = 8;
   localparam int DATA_W = 32;
   localparam int NUM_W = DATA_W + FRAC_BITS;
   localparam int QUO_W = NUM_W;
   localparam int DIV_STAGES = QUO_W;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
      OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
      OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
      OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
   } opcode_type;

   typedef struct packed {
      opcode_type        opcode;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
   } cmd_type;

   typedef struct packed {
      logic [DATA_W-1:0] result;
      logic              compare_true;
      logic              divide_by_zero;
   } rsp_type;
endpackage

// ----- sv/fixed_point_alu_top.sv -----
// Channel   Handshake           Payload
// req       push / full         req_opcode, req_operand_a, req_operand_b
// rsp       pop / empty         rsp_result, rsp_compare_true, rsp_divide_by_zero
// One item per cycle sustained while results are popped; a request passes the command queue,
// the setup stage, the 40-stage divider pipeline and one output register.
// The pipeline advances as a whole and stalls only when the output register is held.
// Reset is synchronous and empties both queues and the pipeline.
// Depends on fpa_pkg, fpa_front and fpa_back.
`timescale 1ns / 1ps
module fixed_point_alu_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic [3:0]                        req_opcode,
   input  logic signed [fpa_pkg::DATA_W-1:0] req_operand_a,
   input  logic signed [fpa_pkg::DATA_W-1:0] req_operand_b,
   output logic                              empty,
   input  logic                              pop,
   output logic signed [fpa_pkg::DATA_W-1:0] rsp_result,
   output logic                              rsp_compare_true,
   output logic                              rsp_divide_by_zero
);
   import fpa_pkg::*;
   `include "assert_macros.svh"

   cmd_type cmd_in, cmd_q;
   logic    cmd_valid, advance, back_valid;
   rsp_type back_rsp, out_ff;
   logic    out_valid_ff, out_valid_in;

   assign cmd_in = '{opcode: opcode_type'(req_opcode), a: req_operand_a, b: req_operand_b};

   fpa_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full), .cmd(cmd_in),
      .cmd_valid(cmd_valid), .cmd_take(advance), .cmd_out(cmd_q)
   );

   assign advance = !back_valid || !out_valid_ff || pop;

   fpa_back u_back (
      .clock(clock), .reset(reset), .in_valid(cmd_valid), .in_cmd(cmd_q),
      .advance(advance), .out_valid(back_valid), .out_rsp(back_rsp)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (pop && out_valid_ff) out_valid_in = 1'b0;
      if (back_valid && advance) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (back_valid && advance) out_ff <= back_rsp;
   end

   assign empty = !out_valid_ff;
   assign rsp_result = out_ff.result;
   assign rsp_compare_true = out_ff.compare_true;
   assign rsp_divide_by_zero = out_ff.divide_by_zero;

   `ASSERT_NEXT(a_out_hold, !empty && !pop, !empty && $stable(rsp_result),
      "result beat changed while waiting")
   `ASSERT_CLK(a_no_drop, !(back_valid && out_valid_ff && !pop && advance),
      "pipeline advanced into a held result")
endmodule

// ----- sv/fpa_front.sv -----
// Front end: accepts request beats into a two-entry command queue.
// Depends on fpa_pkg.
`timescale 1ns / 1ps
module fpa_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  fpa_pkg::cmd_type cmd,
   output logic             cmd_valid,
   input  logic             cmd_take,
   output fpa_pkg::cmd_type cmd_out
);
   import fpa_pkg::*;
   `include "assert_macros.svh"

   cmd_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_out = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= cmd;
      end
   end

   `ASSERT_CLK(a_count_range, count_ff != 2'd3, "command queue count out of range")
   `ASSERT_NEXT(a_full_no_pop, full && !cmd_take, full, "command queue lost an entry")
endmodule

// ----- sv/fpa_back.sv -----
// Back end: pipelined execution with a restoring divider, one stage per quotient bit.
// Depends on fpa_pkg.
`timescale 1ns / 1ps
module fpa_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  fpa_pkg::cmd_type in_cmd,
   input  logic             advance,
   output logic             out_valid,
   output fpa_pkg::rsp_type out_rsp
);
   import fpa_pkg::*;
   `include "assert_macros.svh"

   localparam int PIPE = DIV_STAGES + 1;

   // Stage 0: simple ops resolved, multiply product registered, divider set up.
   logic                   v_ff [PIPE];
   rsp_type                r_ff [PIPE];
   logic                   is_mul_ff;
   logic                   is_div_ff [PIPE];
   logic signed [2*DATA_W-1:0] prod_ff;
   logic [NUM_W-1:0]       num_ff [DIV_STAGES+1];
   logic [DATA_W-1:0]      den_ff [DIV_STAGES+1];
   logic [DATA_W:0]        rem_ff [DIV_STAGES+1];
   logic                   neg_ff [DIV_STAGES+1];

   rsp_type                simple;
   rsp_type                r1_in;
   logic signed [DATA_W-1:0] sa, sb;
   logic [2*DATA_W-1:0]    pmag;
   logic [DATA_W-1:0]      mul_res;
   logic [DATA_W-1:0]      amag, bmag;

   assign sa = signed'(in_cmd.a);
   assign sb = signed'(in_cmd.b);
   assign amag = sa[DATA_W-1] ? (~in_cmd.a + DATA_W'(1)) : in_cmd.a;
   assign bmag = sb[DATA_W-1] ? (~in_cmd.b + DATA_W'(1)) : in_cmd.b;

   always_comb begin
      simple = '0;
      case (in_cmd.opcode)
         OP_ADD: simple.result = in_cmd.a + in_cmd.b;
         OP_SUB: simple.result = in_cmd.a - in_cmd.b;
         OP_GT: simple.compare_true = sa > sb;
         OP_LT: simple.compare_true = sa < sb;
         OP_GE: simple.compare_true = sa >= sb;
         OP_LE: simple.compare_true = sa <= sb;
         OP_EQ: simple.compare_true = sa == sb;
         OP_NE: simple.compare_true = sa != sb;
         OP_MIN: simple.result = (sa < sb) ? in_cmd.a : in_cmd.b;
         OP_MAX: simple.result = (sa > sb) ? in_cmd.a : in_cmd.b;
         OP_INC: simple.result = in_cmd.a + DATA_W'(1);
         OP_DEC: simple.result = in_cmd.a - DATA_W'(1);
         OP_FROM_INT: simple.result = in_cmd.a << FRAC_BITS;
         OP_TO_INT: simple.result = DATA_W'(sa >>> FRAC_BITS);
         OP_DIV: simple.divide_by_zero = (in_cmd.b == '0);
         default: simple = '0;
      endcase
   end

   always_comb begin
      pmag = prod_ff[2*DATA_W-1] ? (~prod_ff + (2*DATA_W)'(1)) : prod_ff;
      mul_res = prod_ff[2*DATA_W-1] ? DATA_W'(~(pmag >> FRAC_BITS) + (2*DATA_W)'(1))
                                     : DATA_W'(pmag >> FRAC_BITS);
      r1_in = r_ff[0];
      if (is_mul_ff) r1_in.result = mul_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE; i++) v_ff[i] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= in_valid;
         for (int i = 1; i < PIPE; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r_ff[0] <= simple;
         is_mul_ff <= (in_cmd.opcode == OP_MUL);
         is_div_ff[0] <= (in_cmd.opcode == OP_DIV) && (in_cmd.b != '0);
         prod_ff <= sa * sb;
         num_ff[0] <= {amag, {FRAC_BITS{1'b0}}};
         den_ff[0] <= bmag;
         rem_ff[0] <= '0;
         neg_ff[0] <= sa[DATA_W-1] ^ sb[DATA_W-1];
         r_ff[1] <= r1_in;
         for (int i = 1; i < PIPE; i++) is_div_ff[i] <= is_div_ff[i-1];
         for (int i = 2; i < PIPE; i++) r_ff[i] <= r_ff[i-1];
         for (int i = 0; i < DIV_STAGES; i++) begin
            logic [DATA_W:0] trial;
            trial = {rem_ff[i][DATA_W-1:0], num_ff[i][NUM_W-1]};
            if (trial >= {1'b0, den_ff[i]}) begin
               rem_ff[i+1] <= trial - {1'b0, den_ff[i]};
               num_ff[i+1] <= {num_ff[i][NUM_W-2:0], 1'b1};
            end else begin
               rem_ff[i+1] <= trial;
               num_ff[i+1] <= {num_ff[i][NUM_W-2:0], 1'b0};
            end
            den_ff[i+1] <= den_ff[i];
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   always_comb begin
      out_valid = v_ff[PIPE-1];
      out_rsp = r_ff[PIPE-1];
      if (is_div_ff[PIPE-1]) begin
         out_rsp.result = neg_ff[DIV_STAGES] ? DATA_W'(~num_ff[DIV_STAGES] + NUM_W'(1))
                                             : DATA_W'(num_ff[DIV_STAGES]);
      end
   end

   `ASSERT_CLK(a_flags_excl, !(out_valid && out_rsp.compare_true && out_rsp.divide_by_zero),
      "compare and divide flags both set")
   `ASSERT_NEXT(a_hold, !advance && out_valid, out_valid, "result lost during stall")
endmodule

// ----- sim/fixed_point_alu_top_tb.sv -----
// Testbench for fixed_point_alu_top: directed and random ALU operations with a
// self-checking predictor and randomized push/pop pacing. Depends on fpa_pkg and the RTL.
`timescale 1ns / 1ps
module fixed_point_alu_top_tb;
   import fpa_pkg::*;

   typedef struct {
      logic signed [31:0] result;
      logic               compare_true;
      logic               divide_by_zero;
   } alu_result_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full, empty;
   logic [3:0] req_opcode = '0;
   logic signed [31:0] req_operand_a = '0;
   logic signed [31:0] req_operand_b = '0;
   logic signed [31:0] rsp_result;
   logic rsp_compare_true, rsp_divide_by_zero;

   alu_result_type expected_results[$];
   int mismatch_count = 0;
   int idle_cycles = 0;
   bit pop_enable = 1'b1;

   fixed_point_alu_top u_dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_opcode(req_opcode), .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b), .empty(empty), .pop(pop),
      .rsp_result(rsp_result), .rsp_compare_true(rsp_compare_true),
      .rsp_divide_by_zero(rsp_divide_by_zero)
   );

   always #6 clock = ~clock;

   function automatic alu_result_type compute_alu(opcode_type op, logic signed [31:0] a,
                                                  logic signed [31:0] b);
      alu_result_type r;
      logic signed [63:0] product;
      logic [63:0] magnitude;
      logic [63:0] numerator;
      logic [63:0] denominator;
      r.result = '0;
      r.compare_true = 1'b0;
      r.divide_by_zero = 1'b0;
      case (op)
         OP_ADD: r.result = a + b;
         OP_SUB: r.result = a - b;
         OP_MUL: begin
            product = 64'(a) * 64'(b);
            magnitude = product < 0 ? -product : product;
            magnitude = magnitude >> FRAC_BITS;
            r.result = product < 0 ? 32'(-magnitude) : 32'(magnitude);
         end
         OP_DIV: begin
            if (b == 0) begin
               r.divide_by_zero = 1'b1;
            end else begin
               numerator = (a < 0 ? -64'(a) : 64'(a)) << FRAC_BITS;
               denominator = b < 0 ? -64'(b) : 64'(b);
               magnitude = numerator / denominator;
               r.result = ((a < 0) != (b < 0)) ? 32'(-magnitude) : 32'(magnitude);
            end
         end
         OP_GT: r.compare_true = a > b;
         OP_LT: r.compare_true = a < b;
         OP_GE: r.compare_true = a >= b;
         OP_LE: r.compare_true = a <= b;
         OP_EQ: r.compare_true = a == b;
         OP_NE: r.compare_true = a != b;
         OP_MIN: r.result = (a < b) ? a : b;
         OP_MAX: r.result = (a > b) ? a : b;
         OP_INC: r.result = a + 1;
         OP_DEC: r.result = a - 1;
         OP_FROM_INT: r.result = a << FRAC_BITS;
         default: r.result = a >>> FRAC_BITS;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] random_operand();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'(int'($urandom_range(0, 8)) - 4);
         3: return 32'($urandom_range(0, 65535)) - 32'd32768;
         4: return {$urandom_range(0, 1) ? 8'hff : 8'h00, 24'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   task automatic send_beat(opcode_type op, logic [31:0] a, logic [31:0] b);
      req_opcode <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      push <= 1'b1;
      do @(posedge clock); while (full);
      expected_results.push_back(compute_alu(op, a, b));
      @(negedge clock);
   endtask

   task automatic idle_gap(int cycles);
      push <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic test_directed_extremes();
      logic [31:0] edges[6] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                                32'h100, 32'hffff_ff00};
      send_beat(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
      send_beat(OP_DIV, 32'h0000_1234, 32'h0);
      send_beat(OP_DIV, 32'h7fff_ffff, 32'h1);
      send_beat(OP_MUL, 32'h8000_0000, 32'h8000_0000);
      send_beat(OP_MUL, 32'hffff_ffff, 32'h1);
      send_beat(OP_MIN, 32'h5, 32'h5);
      send_beat(OP_MAX, 32'h7fff_ffff, 32'h8000_0000);
      send_beat(OP_TO_INT, 32'hffff_ff01, 32'h0);
      send_beat(OP_FROM_INT, 32'h7fff_ffff, 32'hffff_ffff);
      for (int op = 0; op < 16; op++) begin
         send_beat(opcode_type'(op), edges[op % 6], edges[(op + 1) % 6]);
      end
      idle_gap(1);
   endtask

   task automatic test_drain_pause();
      send_beat(OP_DIV, $urandom, $urandom);
      idle_gap(1);
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   task automatic test_random_bursts(int item_count);
      int sent = 0;
      while (sent < item_count) begin
         for (int burst = $urandom_range(1, 40); burst > 0 && sent < item_count; burst--) begin
            send_beat(opcode_type'($urandom_range(0, 15)), random_operand(), random_operand());
            sent++;
         end
         if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
      end
      idle_gap(1);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         case ($urandom_range(0, 9))
            0, 1: pop_enable = ~pop_enable;
            default: ;
         endcase
         pop <= pop_enable ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 4) == 0);
      end
   end

   always @(posedge clock) begin
      alu_result_type exp_r;
      if (!reset && pop && !empty) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected beat: result %h", rsp_result);
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_result !== exp_r.result || rsp_compare_true !== exp_r.compare_true ||
                rsp_divide_by_zero !== exp_r.divide_by_zero) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Mismatch: expected %h/%b/%b, actual %h/%b/%b", exp_r.result,
                           exp_r.compare_true, exp_r.divide_by_zero, rsp_result,
                           rsp_compare_true, rsp_divide_by_zero);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int drain_wait;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_extremes();
      test_drain_pause();
      test_random_bursts(1350);
      drain_wait = 0;
      while (expected_results.size() != 0 && drain_wait < WATCHDOG_LIMIT) begin
         @(negedge clock);
         drain_wait++;
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

// ----- fixed_point_alu_top.f -----
+incdir+sv
sv/fpa_pkg.sv
sv/fpa_front.sv
sv/fpa_back.sv
sv/fixed_point_alu_top.sv
sim/fixed_point_alu_top_tb.sv
